// ===== rtl/bpa_pkg.sv =====
// Shared types and constants for the buddy page allocator.
// Used by bpa_meta_ram and buddy_page_allocator; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

  localparam int MAX_PAGES = 4096;
  localparam int ORDERS    = 12;
  localparam int IDX_W     = $clog2(MAX_PAGES);
  localparam int LNK_W     = IDX_W + 1;
  localparam int ORD_W     = 4;
  localparam int CNT_W     = 13;

  localparam logic [LNK_W-1:0] NIL     = LNK_W'(MAX_PAGES);
  localparam logic [ORD_W-1:0] TOP_ORD = ORD_W'(ORDERS - 1);

  typedef enum logic [1:0] {
    PG_SUB   = 2'd0,
    PG_FREE  = 2'd1,
    PG_ALLOC = 2'd2
  } pg_state_t;

  typedef enum logic [1:0] {
    MODE_INIT  = 2'd0,
    MODE_ALLOC = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_OOM       = 2'd1,
    STAT_NOT_ALLOC = 2'd2
  } status_t;

  typedef struct packed {
    pg_state_t        st;
    logic [ORD_W-1:0] ord;
    logic [LNK_W-1:0] prev;
    logic [LNK_W-1:0] next;
  } meta_t;

  // field-masked write: so covers state and order together
  typedef struct packed {
    logic             en;
    logic             so;
    logic             prev;
    logic             next;
    logic [IDX_W-1:0] addr;
    meta_t            data;
  } meta_wr_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_CARVE, S_CARVE_LNK,
    S_A_RD, S_A_UL, S_A_SEC, S_A_H2, S_A_H, S_A_FRD, S_A_FUL, S_A_FIN,
    S_F_RD, S_F_CHK, S_F_LOOP, S_F_BCHK, S_F_UN, S_F_SUB, S_F_PUSH, S_F_PLNK
  } fsm_t;

endpackage
`default_nettype wire

// ===== rtl/bpa_meta_ram.sv =====
// Per-page metadata store: one write port with field masks, one read port.
// Read data is registered. Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bpa_meta_ram (
  input  wire                           clk,
  input  bpa_pkg::meta_wr_t             wr,
  input  wire                           rd_en,
  input  wire  [bpa_pkg::IDX_W-1:0]     rd_addr,
  output bpa_pkg::meta_t                rd_data
);
  import bpa_pkg::*;

  meta_t mem [MAX_PAGES];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      if (wr.so) begin
        mem[wr.addr].st  <= wr.data.st;
        mem[wr.addr].ord <= wr.data.ord;
      end
      if (wr.prev) mem[wr.addr].prev <= wr.data.prev;
      if (wr.next) mem[wr.addr].next <= wr.data.next;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== rtl/buddy_page_allocator.sv =====
// Buddy page allocator top level: sequencer, free-list heads, config register.
// Depends on bpa_pkg and bpa_meta_ram.
`timescale 1ns / 1ps
`default_nettype none
// One item at a time; start is taken while busy is low and the result comes
// back on done for one cycle, which the receiver must take as it appears.
// Steps are paced by the metadata memory (one write per cycle, registered read
// data). Init clears all 4096 metadata entries, then carves the managed pages
// into free blocks. Allocate splits a larger block down (up to 11 levels) or
// reports out of memory. Free merges with the buddy level by level (up to 11
// levels); a free is rejected if it is out of range or not allocated. Mode 3
// only strobes done.
module buddy_page_allocator (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            start,
  output logic                           busy,
  input  wire  [1:0]                     mode,
  input  wire  [bpa_pkg::ORD_W-1:0]      order,
  input  wire  [bpa_pkg::IDX_W-1:0]      page_index,
  input  wire                            page_count_we,
  input  wire  [bpa_pkg::CNT_W-1:0]      page_count,
  output logic                           done,
  output logic [1:0]                     status,
  output logic [bpa_pkg::IDX_W-1:0]      block_index,
  output logic [bpa_pkg::ORD_W-1:0]      block_order
);
  import bpa_pkg::*;

  fsm_t              state, state_next;
  logic [CNT_W-1:0]  count_cfg;
  logic [CNT_W-1:0]  managed, managed_next;
  logic [LNK_W-1:0]  heads [ORDERS];
  logic [ORD_W-1:0]  q, q_next, req, req_next, ord, ord_next;
  logic [IDX_W-1:0]  idx, idx_next, bud, bud_next, clr_cnt, clr_cnt_next;
  logic [LNK_W-1:0]  lnk_p, lnk_p_next, lnk_n, lnk_n_next;
  logic [CNT_W-1:0]  pos, pos_next;
  logic              done_next;
  logic [1:0]        status_next;
  logic [IDX_W-1:0]  block_index_next;
  logic [ORD_W-1:0]  block_order_next;

  meta_wr_t          mwr;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  meta_t             rd_data;

  logic              hw_en, heads_clr;
  logic [ORD_W-1:0]  hw_sel, hd_sel;
  logic [LNK_W-1:0]  hw_val, hd;

  logic [ORD_W-1:0]  fnd, carve_o, q1, nxt_ord;
  logic              fnd_ok;
  logic [CNT_W-1:0]  rem;
  logic [IDX_W-1:0]  sec, bud_c;

  bpa_meta_ram u_meta (
    .clk     (clk),
    .wr      (mwr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count_cfg <= CNT_W'(MAX_PAGES);
    end else if (page_count_we) begin
      count_cfg <= page_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || heads_clr) begin
      for (int i = 0; i < ORDERS; i++) heads[i] <= NIL;
    end else if (hw_en) begin
      heads[hw_sel] <= hw_val;
    end
  end

  assign hd = heads[hd_sel];

  always_comb begin
    fnd    = '0;
    fnd_ok = 1'b0;
    for (int i = ORDERS - 1; i >= 0; i--) begin
      if (!heads[i][IDX_W] && ORD_W'(i) >= order) begin
        fnd    = ORD_W'(i);
        fnd_ok = 1'b1;
      end
    end
  end

  assign rem = managed - pos;
  always_comb begin
    carve_o = '0;
    for (int o = 1; o < ORDERS; o++) begin
      if (rem >= (CNT_W'(1) << o)) carve_o = ORD_W'(o);
    end
  end

  assign q1      = q - ORD_W'(1);
  assign sec     = idx + (IDX_W'(1) << q1);
  assign bud_c   = idx ^ (IDX_W'(1) << ord);
  assign nxt_ord = ord + ORD_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      managed <= '0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      managed <= managed_next;
      done    <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    q           <= q_next;
    req         <= req_next;
    ord         <= ord_next;
    idx         <= idx_next;
    bud         <= bud_next;
    clr_cnt     <= clr_cnt_next;
    lnk_p       <= lnk_p_next;
    lnk_n       <= lnk_n_next;
    pos         <= pos_next;
    status      <= status_next;
    block_index <= block_index_next;
    block_order <= block_order_next;
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next       = state;
    managed_next     = managed;
    q_next           = q;
    req_next         = req;
    ord_next         = ord;
    idx_next         = idx;
    bud_next         = bud;
    clr_cnt_next     = clr_cnt;
    lnk_p_next       = lnk_p;
    lnk_n_next       = lnk_n;
    pos_next         = pos;
    done_next        = 1'b0;
    status_next      = status;
    block_index_next = block_index;
    block_order_next = block_order;
    mwr              = '0;
    rd_en            = 1'b0;
    rd_addr          = idx;
    hw_en            = 1'b0;
    heads_clr        = 1'b0;
    hw_sel           = ord;
    hw_val           = NIL;
    hd_sel           = ord;

    case (state)
      S_IDLE: begin
        if (start) begin
          status_next      = STAT_OK;
          block_index_next = '0;
          block_order_next = '0;
          case (mode)
            MODE_INIT: begin
              managed_next = (count_cfg > CNT_W'(MAX_PAGES)) ? CNT_W'(MAX_PAGES) : count_cfg;
              clr_cnt_next = '0;
              state_next   = S_CLR;
            end
            MODE_ALLOC: begin
              req_next = order;
              q_next   = fnd;
              if (!fnd_ok) begin
                status_next = STAT_OOM;
                done_next   = 1'b1;
              end else if (fnd == order) begin
                state_next = S_A_FRD;
              end else begin
                state_next = S_A_RD;
              end
            end
            MODE_FREE: begin
              idx_next = page_index;
              if ({1'b0, page_index} >= managed) begin
                status_next = STAT_NOT_ALLOC;
                done_next   = 1'b1;
              end else begin
                state_next = S_F_RD;
              end
            end
            default: done_next = 1'b1;
          endcase
        end
      end

      S_CLR: begin
        mwr.en   = 1'b1;
        mwr.so   = 1'b1;
        mwr.prev = 1'b1;
        mwr.next = 1'b1;
        mwr.addr = clr_cnt;
        mwr.data = '{st: PG_SUB, ord: '0, prev: NIL, next: NIL};
        heads_clr    = (clr_cnt == '0);
        clr_cnt_next = clr_cnt + IDX_W'(1);
        if (clr_cnt == IDX_W'(MAX_PAGES - 1)) begin
          pos_next   = '0;
          state_next = S_CARVE;
        end
      end

      S_CARVE: begin
        if (pos >= managed) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          hd_sel   = carve_o;
          mwr.en   = 1'b1;
          mwr.so   = 1'b1;
          mwr.prev = 1'b1;
          mwr.next = 1'b1;
          mwr.addr = pos[IDX_W-1:0];
          mwr.data = '{st: PG_FREE, ord: carve_o, prev: NIL, next: hd};
          hw_en    = 1'b1;
          hw_sel   = carve_o;
          hw_val   = {1'b0, pos[IDX_W-1:0]};
          idx_next   = pos[IDX_W-1:0];
          lnk_n_next = hd;
          pos_next   = pos + (CNT_W'(1) << carve_o);
          if (!hd[IDX_W]) state_next = S_CARVE_LNK;
        end
      end

      S_CARVE_LNK: begin
        mwr.en        = 1'b1;
        mwr.prev      = 1'b1;
        mwr.addr      = lnk_n[IDX_W-1:0];
        mwr.data      = '0;
        mwr.data.prev = {1'b0, idx};
        state_next    = S_CARVE;
      end

      S_A_RD: begin
        hd_sel     = q;
        idx_next   = hd[IDX_W-1:0];
        rd_en      = 1'b1;
        rd_addr    = hd[IDX_W-1:0];
        state_next = S_A_UL;
      end

      S_A_UL: begin
        hw_en         = 1'b1;
        hw_sel        = q;
        hw_val        = rd_data.next;
        mwr.en        = !rd_data.next[IDX_W];
        mwr.prev      = 1'b1;
        mwr.addr      = rd_data.next[IDX_W-1:0];
        mwr.data      = '0;
        mwr.data.prev = NIL;
        state_next    = S_A_SEC;
      end

      S_A_SEC: begin
        hd_sel     = q1;
        mwr.en     = 1'b1;
        mwr.so     = 1'b1;
        mwr.prev   = 1'b1;
        mwr.next   = 1'b1;
        mwr.addr   = sec;
        mwr.data   = '{st: PG_FREE, ord: q1, prev: {1'b0, idx}, next: hd};
        lnk_n_next = hd;
        bud_next   = sec;
        state_next = hd[IDX_W] ? S_A_H : S_A_H2;
      end

      S_A_H2: begin
        mwr.en        = 1'b1;
        mwr.prev      = 1'b1;
        mwr.addr      = lnk_n[IDX_W-1:0];
        mwr.data      = '0;
        mwr.data.prev = {1'b0, bud};
        state_next    = S_A_H;
      end

      S_A_H: begin
        mwr.en     = 1'b1;
        mwr.so     = 1'b1;
        mwr.prev   = 1'b1;
        mwr.next   = 1'b1;
        mwr.addr   = idx;
        mwr.data   = '{st: PG_FREE, ord: q1, prev: NIL, next: {1'b0, bud}};
        hw_en      = 1'b1;
        hw_sel     = q1;
        hw_val     = {1'b0, idx};
        q_next     = q1;
        state_next = (q1 == req) ? S_A_FRD : S_A_RD;
      end

      S_A_FRD: begin
        hd_sel     = req;
        idx_next   = hd[IDX_W-1:0];
        rd_en      = 1'b1;
        rd_addr    = hd[IDX_W-1:0];
        state_next = S_A_FUL;
      end

      S_A_FUL: begin
        hw_en         = 1'b1;
        hw_sel        = req;
        hw_val        = rd_data.next;
        mwr.en        = !rd_data.next[IDX_W];
        mwr.prev      = 1'b1;
        mwr.addr      = rd_data.next[IDX_W-1:0];
        mwr.data      = '0;
        mwr.data.prev = NIL;
        state_next    = S_A_FIN;
      end

      S_A_FIN: begin
        mwr.en   = 1'b1;
        mwr.so   = 1'b1;
        mwr.prev = 1'b1;
        mwr.next = 1'b1;
        mwr.addr = idx;
        mwr.data = '{st: PG_ALLOC, ord: req, prev: NIL, next: NIL};
        block_index_next = idx;
        block_order_next = req;
        done_next        = 1'b1;
        state_next       = S_IDLE;
      end

      S_F_RD: begin
        rd_en      = 1'b1;
        rd_addr    = idx;
        state_next = S_F_CHK;
      end

      S_F_CHK: begin
        if (rd_data.st != PG_ALLOC) begin
          status_next = STAT_NOT_ALLOC;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          ord_next   = (rd_data.ord > TOP_ORD) ? TOP_ORD : rd_data.ord;
          state_next = S_F_LOOP;
        end
      end

      S_F_LOOP: begin
        bud_next = bud_c;
        if (ord == TOP_ORD || {1'b0, bud_c} >= managed) begin
          state_next = S_F_PUSH;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = bud_c;
          state_next = S_F_BCHK;
        end
      end

      S_F_BCHK: begin
        if (rd_data.st != PG_FREE || rd_data.ord != ord) begin
          state_next = S_F_PUSH;
        end else begin
          lnk_p_next    = rd_data.prev;
          lnk_n_next    = rd_data.next;
          hw_en         = rd_data.prev[IDX_W];
          hw_sel        = ord;
          hw_val        = rd_data.next;
          mwr.en        = !rd_data.prev[IDX_W];
          mwr.next      = 1'b1;
          mwr.addr      = rd_data.prev[IDX_W-1:0];
          mwr.data      = '0;
          mwr.data.next = rd_data.next;
          state_next    = S_F_UN;
        end
      end

      S_F_UN: begin
        mwr.en        = !lnk_n[IDX_W];
        mwr.prev      = 1'b1;
        mwr.addr      = lnk_n[IDX_W-1:0];
        mwr.data      = '0;
        mwr.data.prev = lnk_p;
        state_next    = S_F_SUB;
      end

      S_F_SUB: begin
        mwr.en   = 1'b1;
        mwr.so   = 1'b1;
        mwr.prev = 1'b1;
        mwr.next = 1'b1;
        mwr.addr = (bud < idx) ? idx : bud;
        mwr.data = '{st: PG_SUB, ord: '0, prev: NIL, next: NIL};
        idx_next   = (bud < idx) ? bud : idx;
        ord_next   = nxt_ord;
        state_next = S_F_LOOP;
      end

      S_F_PUSH: begin
        hd_sel     = ord;
        mwr.en     = 1'b1;
        mwr.so     = 1'b1;
        mwr.prev   = 1'b1;
        mwr.next   = 1'b1;
        mwr.addr   = idx;
        mwr.data   = '{st: PG_FREE, ord: ord, prev: NIL, next: hd};
        hw_en      = 1'b1;
        hw_sel     = ord;
        hw_val     = {1'b0, idx};
        lnk_n_next = hd;
        if (hd[IDX_W]) begin
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          state_next = S_F_PLNK;
        end
      end

      S_F_PLNK: begin
        mwr.en        = 1'b1;
        mwr.prev      = 1'b1;
        mwr.addr      = lnk_n[IDX_W-1:0];
        mwr.data      = '0;
        mwr.data.prev = {1'b0, idx};
        done_next     = 1'b1;
        state_next    = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("result strobe while busy");

  a_start_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("accepted item neither ran nor finished");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && status != STAT_OK |-> block_index == '0 && block_order == '0)
    else $error("error result carries a block");

  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy) || $past(start)) else $error("result without an item");

endmodule
`default_nettype wire
